FILE: src/trfr_pkg.sv
// ----------------------------------------------------------------------------
// Token ring frame receiver package
// Shared types and codes of the token ring frame receiver and its checker.
// ----------------------------------------------------------------------------
package trfr_pkg;

	localparam int FRAME_LEN = 8;
	localparam int IDX_W = $clog2(FRAME_LEN);
	localparam int CNT_W = $clog2(FRAME_LEN + 1);

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_POLL_SENT = 2'd1;
	localparam logic [1:0] OP_CLAIM_FIRST = 2'd2;
	localparam logic [1:0] OP_CALL_SERVED = 2'd3;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_ANNOUNCE = 3'd1;
	localparam logic [2:0] KIND_POLL_ME = 3'd2;
	localparam logic [2:0] KIND_ACK_ME = 3'd3;
	localparam logic [2:0] KIND_OTHER = 3'd4;
	localparam logic [2:0] KIND_DROP = 3'd5;

	localparam logic [7:0] HDR_ANNOUNCE = 8'hAA;
	localparam logic [7:0] HDR_POLL = 8'h55;
	localparam logic [7:0] HDR_ZERO = 8'h00;
	localparam logic [7:0] HDR_ACK2 = 8'h55;
	localparam logic [7:0] NODE_DEFAULT = 8'd127;
	localparam logic [7:0] WAIT_LIMIT = 8'd5;
	localparam logic [7:0] MY_ID_RESET = 8'd1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [2:0] frame_kind;
		logic [7:0] next_node;
		logic       is_first;
		logic       called;
		logic [7:0] caller;
		logic       ack_seen;
		logic [7:0] ack_wait;
	} out_t;

endpackage

FILE: src/token_ring_frame_receiver.sv
// ----------------------------------------------------------------------------
// Token ring frame receiver
// Collects bus bytes into a frame window, decodes announce, poll and ack
// frames, and keeps the token ring node state.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the in channel (in_valid, in_ready, in_data). Each beat
// carries an opcode and a received byte; exactly one result beat leaves on
// the out channel (out_valid, out_ready, out_data) for every input beat.
// A result shows the frame kind decoded by that beat and the node state
// after it. cfg_we writes cfg_wdata into the node address on any edge;
// the user must change it only while the block holds no beat, since the
// block itself does not enforce this. A beat passes the input register,
// then the decode and state update, which load the output register. One
// beat is accepted every cycle as long as the output is taken; the state
// loop runs from the state registers through the decode logic and back.
// Reset clears the window, the other node state and both valid flags, and
// sets the node address to 1, the next node to 127 and the first flag.
// When out_ready is low the result holds; the input register keeps one
// more beat, and in_ready then drops until the output moves.
// ----------------------------------------------------------------------------
module token_ring_frame_receiver import trfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic             valid_s1;
	in_t              data_s1;
	logic             adv;
	logic [7:0]       my_id_q;
	logic [7:0]       window_q [FRAME_LEN];
	logic [CNT_W-1:0] fill_q;
	logic [7:0]       next_q;
	logic             first_q;
	logic             called_q;
	logic [7:0]       caller_q;
	logic             ack_q;
	logic [7:0]       wait_q;
	logic             out_valid_q;
	out_t             out_q;

	logic [7:0]       win_full [FRAME_LEN];
	logic [7:0]       window_d [FRAME_LEN];
	logic [CNT_W-1:0] fill_d;
	logic [7:0]       next_d;
	logic             first_d;
	logic             called_d;
	logic [7:0]       caller_d;
	logic             ack_d;
	logic [7:0]       wait_d;
	logic [2:0]       kind_d;
	logic [7:0]       wait_inc;

	assign adv = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		for (int i = 0; i < FRAME_LEN; i++) begin
			win_full[i] = window_q[i];
			window_d[i] = window_q[i];
		end
		fill_d = fill_q;
		next_d = next_q;
		first_d = first_q;
		called_d = called_q;
		caller_d = caller_q;
		ack_d = ack_q;
		wait_d = wait_q;
		kind_d = KIND_NONE;
		wait_inc = (wait_q == 8'hFF) ? wait_q : wait_q + 8'd1;
		unique case (data_s1.opcode)
			OP_BYTE: begin
				win_full[fill_q[IDX_W-1:0]] = data_s1.rx_byte;
				for (int i = 0; i < FRAME_LEN; i++) begin
					window_d[i] = win_full[i];
				end
				fill_d = fill_q + CNT_W'(1);
				if (fill_q == CNT_W'(FRAME_LEN - 1)) begin
					for (int i = 0; i < FRAME_LEN; i++) begin
						window_d[i] = 8'h00;
					end
					fill_d = '0;
					if (win_full[0] == HDR_ANNOUNCE && win_full[1] == HDR_ZERO) begin
						kind_d = KIND_ANNOUNCE;
						if (win_full[2] < my_id_q) begin
							first_d = 1'b0;
						end
						if (win_full[2] < next_q && win_full[2] > my_id_q) begin
							next_d = win_full[2];
						end
					end else if (win_full[0] == HDR_POLL && win_full[1] == HDR_ZERO) begin
						kind_d = KIND_OTHER;
						if (win_full[2] == my_id_q) begin
							kind_d = KIND_POLL_ME;
							called_d = 1'b1;
							caller_d = win_full[4];
						end
					end else if (win_full[0] == HDR_POLL && win_full[1] == HDR_ACK2) begin
						kind_d = KIND_OTHER;
						if (win_full[2] == my_id_q) begin
							kind_d = KIND_ACK_ME;
							ack_d = 1'b1;
							wait_d = 8'h00;
						end
					end else begin
						kind_d = KIND_DROP;
						for (int i = 0; i < FRAME_LEN - 1; i++) begin
							window_d[i] = win_full[i + 1];
						end
						window_d[FRAME_LEN-1] = 8'h00;
						fill_d = CNT_W'(FRAME_LEN - 1);
					end
				end
			end
			OP_POLL_SENT: begin
				wait_d = wait_inc;
				if (wait_inc > WAIT_LIMIT) begin
					next_d = NODE_DEFAULT;
				end
			end
			OP_CLAIM_FIRST: begin
				first_d = 1'b1;
			end
			OP_CALL_SERVED: begin
				called_d = 1'b0;
				caller_d = 8'h00;
			end
			default: begin
				kind_d = KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_id_q <= MY_ID_RESET;
		end else if (cfg_we) begin
			my_id_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_LEN; i++) begin
				window_q[i] <= 8'h00;
			end
			fill_q <= '0;
			next_q <= NODE_DEFAULT;
			first_q <= 1'b1;
			called_q <= 1'b0;
			caller_q <= 8'h00;
			ack_q <= 1'b0;
			wait_q <= 8'h00;
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			for (int i = 0; i < FRAME_LEN; i++) begin
				window_q[i] <= window_d[i];
			end
			fill_q <= fill_d;
			next_q <= next_d;
			first_q <= first_d;
			called_q <= called_d;
			caller_q <= caller_d;
			ack_q <= ack_d;
			wait_q <= wait_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			out_q.frame_kind <= kind_d;
			out_q.next_node <= next_d;
			out_q.is_first <= first_d;
			out_q.called <= called_d;
			out_q.caller <= caller_d;
			out_q.ack_seen <= ack_d;
			out_q.ack_wait <= wait_d;
		end
	end

endmodule

FILE: src/trfr_checker.sv
// ----------------------------------------------------------------------------
// Token ring frame receiver checker
// Port level assertions for the token ring frame receiver, bound to it.
// ----------------------------------------------------------------------------
module trfr_checker import trfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Result beat changed while stalled.");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.frame_kind <= KIND_DROP)
		else $error("Frame kind out of range.");

	a_ack_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_kind == KIND_ACK_ME |->
			out_data.ack_seen && out_data.ack_wait == 8'h00)
		else $error("Ack for this node did not update the ack state.");

	a_poll_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_kind == KIND_POLL_ME |-> out_data.called)
		else $error("Poll for this node did not set the called flag.");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("Result beat present right after reset.");

endmodule

bind token_ring_frame_receiver trfr_checker u_trfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
